// ----- sv/thb_pkg.sv -----
package thb_pkg;

	localparam int BIN_COUNT   = 5;
	localparam int LIMIT_REGS  = 5;
	localparam int BIN_W       = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
	localparam int SAMPLE_W    = 16;
	localparam int TOTAL_W     = 32;
	localparam int INDEX_W     = 3;
	localparam int MODE_W      = 2;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int IN_DATA_W   = 16;
	localparam int OUT_DATA_W  = 40;

	localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(BIN_COUNT - 1);

	typedef logic [SAMPLE_W-1:0] limit_t;
	typedef limit_t [BIN_COUNT-1:0] limit_arr_t;

	localparam limit_t LIMIT_RESET [LIMIT_REGS] = '{
		16'd13107, 16'd26214, 16'd39321, 16'd52428, 16'd65535
	};

	typedef enum logic [MODE_W-1:0] {
		MODE_COUNT   = 2'd0,
		MODE_READOUT = 2'd1,
		MODE_CLEAR   = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_COUNT  = 2'd1,
		KIND_REPORT = 2'd2
	} kind_t;

	// control from the pipeline to the count store
	typedef struct packed {
		logic             rd_en;
		logic [BIN_W-1:0] rd_addr;
		logic             wr_en;
		logic [BIN_W-1:0] wr_addr;
		logic             clear;
	} mem_ctrl_t;

	function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
		sat_inc = (v == {TOTAL_W{1'b1}}) ? v : v + TOTAL_W'(1);
	endfunction

endpackage

// ----- sv/thb_bin_select.sv -----
module thb_bin_select
	import thb_pkg::*;
(
	input  limit_t           sample,
	input  limit_arr_t       limits,
	output logic [BIN_W-1:0] bin_sel
);

	// first bin whose limit is not exceeded; above all limits lands in the last bin
	always_comb begin
		bin_sel = LAST_BIN;
		for (int i = BIN_COUNT - 1; i >= 0; i--) begin
			if (sample <= limits[i]) begin
				bin_sel = BIN_W'(i);
			end
		end
	end

endmodule

// ----- sv/thb_count_mem.sv -----
module thb_count_mem
	import thb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  mem_ctrl_t          ctrl,
	input  logic [TOTAL_W-1:0] wr_data,
	output logic [TOTAL_W-1:0] rd_data
);

	logic [TOTAL_W-1:0]   mem_q [BIN_COUNT];
	logic [BIN_COUNT-1:0] valid_q;
	logic [TOTAL_W-1:0]   rdata_q;
	logic                 rvld_q;
	logic                 byp_hit_q;
	logic [TOTAL_W-1:0]   byp_data_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem_q[ctrl.wr_addr] <= wr_data;
		end
		if (ctrl.rd_en) begin
			rdata_q    <= mem_q[ctrl.rd_addr];
			byp_data_q <= wr_data;
		end
	end

	// entry not written since reset or clear reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rvld_q    <= 1'b0;
			byp_hit_q <= 1'b0;
		end else begin
			if (ctrl.clear) begin
				valid_q <= '0;
			end else if (ctrl.wr_en) begin
				valid_q[ctrl.wr_addr] <= 1'b1;
			end
			if (ctrl.rd_en) begin
				rvld_q    <= valid_q[ctrl.rd_addr] && !ctrl.clear;
				// write landing at the same edge as the read: forward it
				byp_hit_q <= ctrl.wr_en && (ctrl.wr_addr == ctrl.rd_addr) && !ctrl.clear;
			end
		end
	end

	assign rd_data = byp_hit_q ? byp_data_q : (rvld_q ? rdata_q : '0);

endmodule

// ----- sv/threshold_histogram_binning.sv -----
// Histogram engine over unsigned 16-bit samples in hundredths.
// Input stream: in_tuser carries the request mode (count, readout, clear),
// in_tdata the sample. Bin limits are written over the cfg channel (index
// 0..4, one 16-bit limit each, cfg_ready always high); the user must write
// them only while the block is idle; the block does not enforce it. A count
// request places the sample in the first bin whose limit it does not exceed
// (the last bin when above all) and bumps that bin's saturating 32-bit count.
// Count and clear requests are taken one per cycle, back to back, unless a
// readout blocks input; counts live in a small synchronous RAM, read at
// accept, incremented and written back in the next cycle, with a forwarding
// path for repeated bins. A readout request emits BIN_COUNT results, one per
// cycle while out_tready is high, bin 0 first, out_tlast on the last; input
// is held off while the RAM port sweeps the bins. The first result passes
// the RAM read register and s1 before the output. When the receiver stalls,
// the output register holds; a further result in s1 holds too and drops
// in_tready until the output drains. Reset restores the default limits and
// all counts read as zero; a clear request zeroes the counts at once.
module threshold_histogram_binning
	import thb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_tvalid,
	output logic                  in_tready,
	input  logic [IN_DATA_W-1:0]  in_tdata,   // [15:0] sample_value
	input  logic [MODE_W-1:0]     in_tuser,   // [1:0] mode
	output logic                  out_tvalid,
	input  logic                  out_tready,
	output logic [OUT_DATA_W-1:0] out_tdata,  // [2:0] bin_index, [34:3] bin_total, zero pad
	output logic                  out_tlast,  // last_bin
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	limit_arr_t         limits_q;
	logic [BIN_W-1:0]   bin_sel;
	logic               accept;
	mode_t              in_mode;
	kind_t              in_kind;
	logic               busy_q;
	logic [BIN_W-1:0]   cnt_q;
	kind_t              kind_s1;
	logic [BIN_W-1:0]   addr_s1;
	logic               last_s1;
	logic               stall_s1;
	logic               advance;
	mem_ctrl_t          mem_ctrl;
	logic [TOTAL_W-1:0] rd_data;
	logic               out_valid_q;
	logic [BIN_W-1:0]   out_idx_q;
	logic [TOTAL_W-1:0] out_total_q;
	logic               out_last_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BIN_COUNT; i++) begin
				limits_q[i] <= LIMIT_RESET[i];
			end
		end else if (cfg_valid && cfg_index < CFG_IDX_W'(BIN_COUNT)) begin
			limits_q[cfg_index] <= cfg_data;
		end
	end

	thb_bin_select u_sel (
		.sample  (in_tdata[SAMPLE_W-1:0]),
		.limits  (limits_q),
		.bin_sel (bin_sel)
	);

	assign in_mode  = mode_t'(in_tuser);
	assign stall_s1 = (kind_s1 == KIND_REPORT) && out_valid_q && !out_tready;
	assign advance  = !stall_s1;
	assign in_tready = !busy_q && !stall_s1;
	assign accept   = in_tvalid && in_tready;

	always_comb begin
		unique case (in_mode)
			MODE_COUNT:   in_kind = KIND_COUNT;
			MODE_READOUT: in_kind = KIND_REPORT;
			default:      in_kind = KIND_NONE;
		endcase
	end

	always_comb begin
		mem_ctrl.rd_en   = advance;
		mem_ctrl.rd_addr = busy_q ? cnt_q : (in_mode == MODE_READOUT ? '0 : bin_sel);
		mem_ctrl.wr_en   = (kind_s1 == KIND_COUNT);
		mem_ctrl.wr_addr = addr_s1;
		mem_ctrl.clear   = accept && (in_mode == MODE_CLEAR);
	end

	thb_count_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (mem_ctrl),
		.wr_data (sat_inc(rd_data)),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			kind_s1 <= KIND_NONE;
		end else begin
			if (accept && in_mode == MODE_READOUT) begin
				busy_q <= 1'b1;
				cnt_q  <= BIN_W'(1);
			end else if (busy_q && advance) begin
				if (cnt_q == LAST_BIN) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q + BIN_W'(1);
			end
			if (advance) begin
				if (busy_q) begin
					kind_s1 <= KIND_REPORT;
				end else if (accept) begin
					kind_s1 <= in_kind;
				end else begin
					kind_s1 <= KIND_NONE;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			addr_s1 <= mem_ctrl.rd_addr;
			last_s1 <= busy_q && (cnt_q == LAST_BIN);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && kind_s1 == KIND_REPORT) begin
			out_valid_q <= 1'b1;
		end else if (out_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && kind_s1 == KIND_REPORT) begin
			out_idx_q   <= addr_s1;
			out_total_q <= rd_data;
			out_last_q  <= last_s1;
		end
	end

	assign out_tvalid = out_valid_q;
	assign out_tlast  = out_last_q;
	assign out_tdata  = {{(OUT_DATA_W - TOTAL_W - INDEX_W){1'b0}}, out_total_q,
		INDEX_W'(out_idx_q)};

endmodule

// ----- sv/thb_checker.sv -----
module thb_checker
	import thb_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_tvalid,
	input logic                  in_tready,
	input logic [MODE_W-1:0]     in_tuser,
	input logic                  out_tvalid,
	input logic                  out_tready,
	input logic [OUT_DATA_W-1:0] out_tdata,
	input logic                  out_tlast
);

	localparam logic [INDEX_W-1:0] LAST_IDX = INDEX_W'(BIN_COUNT - 1);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
		else $error("result dropped or changed while stalled");

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_tvalid |-> (out_tlast == (out_tdata[INDEX_W-1:0] == LAST_IDX)))
		else $error("last marker not on the final bin");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_tvalid |-> out_tdata[INDEX_W-1:0] <= LAST_IDX)
		else $error("bin index out of range");

	a_readout_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_tvalid && in_tready && in_tuser == MODE_READOUT |=> !in_tready)
		else $error("request taken during readout sweep");

endmodule

bind threshold_histogram_binning thb_checker u_thb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_tvalid  (in_tvalid),
	.in_tready  (in_tready),
	.in_tuser   (in_tuser),
	.out_tvalid (out_tvalid),
	.out_tready (out_tready),
	.out_tdata  (out_tdata),
	.out_tlast  (out_tlast)
);
